// File: rtl/psp_pkg.sv
package psp_pkg;

  localparam int COORD_W = 32;
  localparam int DIST_W  = 31;
  localparam int CODE_W  = 2;

  // Squared length and dot product widths for 33-bit coordinate differences.
  localparam int LEN2_W  = 66;
  localparam int DOT_W   = 68;

  // Foot divider: numerator 2*|d|*dot + len2, denominator 2*len2.
  localparam int QUO_W   = 33;
  localparam int DEN_W   = 67;
  localparam int NUM_W   = DEN_W + QUO_W;

  // Distance: sum of three 64-bit squares, square root of the low 64 bits.
  localparam int SQ_W    = 66;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int REM_W   = 34;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CODE_W-1:0] CODE_INTERIOR = 2'd0;
  localparam logic [CODE_W-1:0] CODE_START    = 2'd1;
  localparam logic [CODE_W-1:0] CODE_END      = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic signed [COORD_W-1:0] near_z;
    logic [DIST_W-1:0]         distance;
    logic [CODE_W-1:0]         where_found;
  } out_item_t;

  // One classified item, handed from the front end to the back end.
  typedef struct packed {
    vec3_t               p;
    vec3_t               base;
    logic [2:0][COORD_W-1:0] md;
    logic [2:0]          dneg;
    logic [LEN2_W-1:0]   len2;
    logic [LEN2_W-1:0]   dot;
    logic [CODE_W-1:0]   code;
  } entry_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    vec3_t             p;
    vec3_t             base;
    logic [2:0]        dneg;
    logic [CODE_W-1:0] code;
  } div_side_t;

  // Data that rides alongside the square root.
  typedef struct packed {
    vec3_t             r;
    logic [CODE_W-1:0] code;
    logic              sat;
  } sqrt_side_t;

endpackage

// File: rtl/psp_front.sv
module psp_front
  import psp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     push,
  output entry_t   push_entry
);

  logic en;
  logic f1_v_r, f2_v_r, f3_v_r;

  vec3_t pin, ain, bin;
  logic [2:0][COORD_W:0] d_c, w_c;

  vec3_t f1_p_r, f1_a_r, f1_b_r;
  logic [2:0][COORD_W:0] f1_d_r, f1_w_r;

  logic [2:0][COORD_W-1:0] md_c;
  logic [2:0][63:0] dd_c;
  logic signed [65:0] wd_c [3];

  vec3_t f2_p_r, f2_a_r, f2_b_r;
  logic [2:0] f2_dneg_r;
  logic [2:0][COORD_W-1:0] f2_md_r;
  logic [2:0][63:0] f2_dd_r;
  logic [2:0][65:0] f2_wd_r;

  vec3_t f3_p_r, f3_a_r, f3_b_r;
  logic [2:0] f3_dneg_r;
  logic [2:0][COORD_W-1:0] f3_md_r;
  logic [LEN2_W-1:0] f3_len2_r;
  logic [DOT_W-1:0] f3_dot_r;

  // The whole front end holds when its last stage cannot drain into the queue.
  assign en       = !f3_v_r || !q_full;
  assign in_ready = en;
  assign push     = f3_v_r && !q_full;

  always_comb begin
    pin = {in_item.point_z, in_item.point_y, in_item.point_x};
    ain = {in_item.start_z, in_item.start_y, in_item.start_x};
    bin = {in_item.end_z, in_item.end_y, in_item.end_x};
    for (int i = 0; i < 3; i++) begin
      d_c[i] = {bin[i][COORD_W-1], bin[i]} - {ain[i][COORD_W-1], ain[i]};
      w_c[i] = {pin[i][COORD_W-1], pin[i]} - {ain[i][COORD_W-1], ain[i]};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      md_c[i] = f1_d_r[i][COORD_W] ? (~f1_d_r[i][COORD_W-1:0] + 32'd1)
                                   : f1_d_r[i][COORD_W-1:0];
      dd_c[i] = {32'd0, md_c[i]} * {32'd0, md_c[i]};
      wd_c[i] = $signed(f1_w_r[i]) * $signed(f1_d_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_p_r <= pin;
      f1_a_r <= ain;
      f1_b_r <= bin;
      f1_d_r <= d_c;
      f1_w_r <= w_c;

      f2_p_r <= f1_p_r;
      f2_a_r <= f1_a_r;
      f2_b_r <= f1_b_r;
      f2_md_r <= md_c;
      f2_dd_r <= dd_c;
      for (int i = 0; i < 3; i++) begin
        f2_dneg_r[i] <= f1_d_r[i][COORD_W];
        f2_wd_r[i]   <= wd_c[i];
      end

      f3_p_r    <= f2_p_r;
      f3_a_r    <= f2_a_r;
      f3_b_r    <= f2_b_r;
      f3_md_r   <= f2_md_r;
      f3_dneg_r <= f2_dneg_r;
      f3_len2_r <= {2'b00, f2_dd_r[0]} + {2'b00, f2_dd_r[1]} + {2'b00, f2_dd_r[2]};
      f3_dot_r  <= {{2{f2_wd_r[0][65]}}, f2_wd_r[0]} + {{2{f2_wd_r[1][65]}}, f2_wd_r[1]}
                 + {{2{f2_wd_r[2][65]}}, f2_wd_r[2]};
    end
  end

  // A foot parameter below zero or a degenerate segment picks the start point,
  // a parameter above one picks the end point, anything else is interior.
  always_comb begin
    push_entry.p    = f3_p_r;
    push_entry.md   = f3_md_r;
    push_entry.dneg = f3_dneg_r;
    push_entry.len2 = f3_len2_r;
    push_entry.dot  = f3_dot_r[LEN2_W-1:0];
    push_entry.base = f3_a_r;
    if (f3_len2_r == '0 || f3_dot_r[DOT_W-1]) begin
      push_entry.code = CODE_START;
    end else if (f3_dot_r > {2'b00, f3_len2_r}) begin
      push_entry.code = CODE_END;
      push_entry.base = f3_b_r;
    end else begin
      push_entry.code = CODE_INTERIOR;
    end
  end

endmodule

// File: rtl/psp_div.sv
module psp_div
  import psp_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  // Restoring division, one quotient bit per stage. The low register holds the
  // numerator bits still to come and collects quotient bits from the right.
  logic [DEN_W-1:0] rem_r [QUO_W+1];
  logic [QUO_W-1:0] lq_r  [QUO_W+1];
  logic [DEN_W-1:0] den_r [QUO_W+1];

  logic [DEN_W-1:0] rem_nxt [QUO_W];
  logic [QUO_W-1:0] lq_nxt  [QUO_W];

  always_comb begin
    logic [DEN_W:0]   sh;
    logic [DEN_W+1:0] diff;
    sh   = '0;
    diff = '0;
    for (int k = 0; k < QUO_W; k++) begin
      sh   = {rem_r[k], lq_r[k][QUO_W-1]};
      diff = {1'b0, sh} - {2'b00, den_r[k]};
      rem_nxt[k] = diff[DEN_W+1] ? sh[DEN_W-1:0] : diff[DEN_W-1:0];
      lq_nxt[k]  = {lq_r[k][QUO_W-2:0], ~diff[DEN_W+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[NUM_W-1 -: DEN_W];
      lq_r[0]  <= num[QUO_W-1:0];
      den_r[0] <= den;
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        lq_r[k+1]  <= lq_nxt[k];
        den_r[k+1] <= den_r[k];
      end
    end
  end

  assign quo = lq_r[QUO_W];

endmodule

// File: rtl/psp_sqrt.sv
module psp_sqrt
  import psp_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root,
  output logic [REM_W-1:0]  rem
);

  // Digit-by-digit square root, one root bit per stage.
  logic [REM_W-1:0]  rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];
  logic [RAD_W-1:0]  v_r    [ROOT_W+1];

  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];

  always_comb begin
    logic [REM_W+1:0] sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+2:0] diff;
    sh    = '0;
    trial = '0;
    diff  = '0;
    for (int k = 0; k < ROOT_W; k++) begin
      sh    = {rem_r[k], v_r[k][RAD_W-1 -: 2]};
      trial = {2'b00, root_r[k], 2'b01};
      diff  = {1'b0, sh} - {1'b0, trial};
      rem_nxt[k]  = diff[REM_W+2] ? sh[REM_W-1:0] : diff[REM_W-1:0];
      root_nxt[k] = {root_r[k][ROOT_W-2:0], ~diff[REM_W+2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      v_r[0]    <= rad;
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k+1]  <= rem_nxt[k];
        root_r[k+1] <= root_nxt[k];
        v_r[k+1]    <= {v_r[k][RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[ROOT_W];
  assign rem  = rem_r[ROOT_W];

endmodule

// File: rtl/psp_back.sv
module psp_back
  import psp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  entry_t    head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int VLD_N = 2 + (QUO_W + 1) + 2 + (ROOT_W + 1);

  logic en;
  logic [VLD_N-1:0] vld_r;
  logic out_valid_r;
  out_item_t out_item_r;

  entry_t s0_r;
  logic [2:0][64:0] lo_c, hi_c;

  div_side_t s1_side_r;
  logic [2:0][64:0] s1_lo_r, s1_hi_r;
  logic [LEN2_W-1:0] s1_len2_r;

  logic [2:0][NUM_W-1:0] num_c;
  logic [DEN_W-1:0] den_c;
  logic [2:0][QUO_W-1:0] quo;
  div_side_t dsd_r [QUO_W+1];

  vec3_t r_c;
  logic [2:0][COORD_W-1:0] emag_c;
  vec3_t sr_r_r;
  logic [2:0][COORD_W-1:0] sr_emag_r;
  logic [CODE_W-1:0] sr_code_r;

  vec3_t sq_r_r;
  logic [2:0][63:0] sq_r;
  logic [CODE_W-1:0] sq_code_r;

  logic [SQ_W-1:0] sum_c;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0] rem;
  sqrt_side_t qsd_r [ROOT_W+1];
  sqrt_side_t tail;

  logic [ROOT_W:0] rounded_c;
  out_item_t out_c;

  // The back end moves as one pipeline whenever the output register can take.
  assign en        = !out_valid_r || out_ready;
  assign pop       = en && head_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VLD_N-2:0], head_valid};
      out_valid_r <= vld_r[VLD_N-1];
    end
  end

  // |d| * dot is split into two partial products over the two halves of dot.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_c[i] = 65'(s0_r.md[i]) * 65'(s0_r.dot[32:0]);
      hi_c[i] = 65'(s0_r.md[i]) * 65'(s0_r.dot[LEN2_W-1:33]);
    end
  end

  always_comb begin
    logic [97:0] prod;
    prod = '0;
    for (int i = 0; i < 3; i++) begin
      prod     = {s1_hi_r[i], 33'd0} + {33'd0, s1_lo_r[i]};
      num_c[i] = {1'b0, prod, 1'b0} + {{(NUM_W-LEN2_W){1'b0}}, s1_len2_r};
    end
    den_c = {s1_len2_r, 1'b0};
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    psp_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_c[i]),
      .den (den_c),
      .quo (quo[i])
    );
  end

  // Rebuild the chosen point; only an interior foot takes the rounded offset.
  always_comb begin
    logic [COORD_W:0] off;
    logic [COORD_W:0] r33;
    logic [COORD_W:0] e33;
    off = '0;
    r33 = '0;
    e33 = '0;
    for (int i = 0; i < 3; i++) begin
      off = (dsd_r[QUO_W].code == CODE_INTERIOR) ? {1'b0, quo[i][COORD_W-1:0]} : '0;
      if (dsd_r[QUO_W].dneg[i]) begin
        off = ~off + 33'd1;
      end
      r33 = {dsd_r[QUO_W].base[i][COORD_W-1], dsd_r[QUO_W].base[i]} + off;
      r_c[i] = r33[COORD_W-1:0];
      e33 = {r_c[i][COORD_W-1], r_c[i]}
          - {dsd_r[QUO_W].p[i][COORD_W-1], dsd_r[QUO_W].p[i]};
      emag_c[i] = e33[COORD_W] ? (~e33[COORD_W-1:0] + 32'd1) : e33[COORD_W-1:0];
    end
  end

  assign sum_c = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};

  psp_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum_c[RAD_W-1:0]),
    .root (root),
    .rem  (rem)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= head;

      s1_side_r.p    <= s0_r.p;
      s1_side_r.base <= s0_r.base;
      s1_side_r.dneg <= s0_r.dneg;
      s1_side_r.code <= s0_r.code;
      s1_lo_r        <= lo_c;
      s1_hi_r        <= hi_c;
      s1_len2_r      <= s0_r.len2;

      dsd_r[0] <= s1_side_r;
      for (int k = 0; k < QUO_W; k++) begin
        dsd_r[k+1] <= dsd_r[k];
      end

      sr_r_r    <= r_c;
      sr_emag_r <= emag_c;
      sr_code_r <= dsd_r[QUO_W].code;

      sq_r_r    <= sr_r_r;
      sq_code_r <= sr_code_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= {32'd0, sr_emag_r[i]} * {32'd0, sr_emag_r[i]};
      end

      qsd_r[0].r    <= sq_r_r;
      qsd_r[0].code <= sq_code_r;
      qsd_r[0].sat  <= |sum_c[SQ_W-1:RAD_W];
      for (int k = 0; k < ROOT_W; k++) begin
        qsd_r[k+1] <= qsd_r[k];
      end

      out_item_r <= out_c;
    end
  end

  // Round to nearest: step up when the remainder exceeds the truncated root.
  always_comb begin
    tail      = qsd_r[ROOT_W];
    rounded_c = {1'b0, root} + {{ROOT_W{1'b0}}, (rem > {2'b00, root})};
    out_c.near_x      = tail.r[0];
    out_c.near_y      = tail.r[1];
    out_c.near_z      = tail.r[2];
    out_c.where_found = tail.code;
    if (tail.sat || rounded_c[ROOT_W:DIST_W] != '0) begin
      out_c.distance = DIST_MAX;
    end else begin
      out_c.distance = rounded_c[DIST_W-1:0];
    end
  end

endmodule

// File: rtl/point_segment_projection_core.sv
// Closest point on a 3D segment, signed Q16.16 coordinates.
// Input channel (in_valid/in_ready/in_item) takes a query point and the two
// segment endpoints; the result channel (out_valid/out_ready/out_item) gives
// the closest point on the segment, its distance to the query point and a
// code: interior foot, start point (also for a degenerate segment) or end point.
// Throughput is one item per cycle while out_ready stays high. On its way to
// out_valid an accepted item passes three front-end stages that form the
// dot product and squared length and classify the item, a queue write, then
// a back end of two partial-product stages, a 34-stage foot divider, two
// stages for the point and the squared error, a 33-stage square root and the
// output register.
// A stall on out_ready freezes the back end; the front end keeps accepting
// until the queue between the two fills, then drops in_ready.
// rst_n (synchronous, active low) empties the queue and all stages; no item
// is in flight after reset.
module point_segment_projection_core
  import psp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic   q_push, q_pop, q_full, q_empty;
  entry_t push_entry;
  entry_t q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] q_count_r;

  psp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (push_entry)
  );

  assign q_full  = (q_count_r == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (q_count_r == '0);

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_count_r <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (q_push && !q_pop) begin
        q_count_r <= q_count_r + 1'b1;
      end else if (q_pop && !q_push) begin
        q_count_r <= q_count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wr_ptr_r] <= push_entry;
    end
  end

  psp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!q_empty),
    .head       (q_mem[rd_ptr_r]),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

`ifndef SYNTH
  a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_queue_grow : assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_count_r == $past(q_count_r) + 1'b1))
    else $error("queue count did not follow a lone push");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count_r != '0))
    else $error("item taken from an empty queue");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import psp_pkg::*;

  class projection_scoreboard;
    out_item_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Exact closest point, distance and case code for one item.
    function out_item_t project(in_item_t it);
      logic signed [33:0] p[3], a[3], b[3], d[3], w[3], r[3], e[3];
      logic signed [71:0] len2, dot;
      logic [71:0] num, den, q;
      logic [71:0] sq;
      logic [63:0] rad, root, rem, trial;
      out_item_t res;
      p[0] = it.point_x; p[1] = it.point_y; p[2] = it.point_z;
      a[0] = it.start_x; a[1] = it.start_y; a[2] = it.start_z;
      b[0] = it.end_x;   b[1] = it.end_y;   b[2] = it.end_z;
      len2 = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = b[i] - a[i];
        w[i] = p[i] - a[i];
        len2 += 72'(d[i]) * 72'(d[i]);
        dot += 72'(w[i]) * 72'(d[i]);
      end
      if (len2 == 0 || dot < 0) begin
        r = a;
        res.where_found = CODE_START;
      end else if (dot > len2) begin
        r = b;
        res.where_found = CODE_END;
      end else begin
        // The product |d|*dot needs close to 100 bits, so the division runs at 136.
        for (int i = 0; i < 3; i++) begin
          logic [135:0] wn, wd, wq;
          logic [33:0] md;
          md = d[i] < 0 ? -d[i] : d[i];
          wn = 2 * (136'(md) * 136'(dot)) + 136'(len2);
          wd = 2 * 136'(len2);
          wq = wn / wd;
          r[i] = d[i] < 0 ? a[i] - 34'(wq) : a[i] + 34'(wq);
        end
        res.where_found = CODE_INTERIOR;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        e[i] = r[i] - p[i];
        sq += 72'(e[i]) * 72'(e[i]);
      end
      if (sq[71:64] != 0) begin
        res.distance = DIST_MAX;
      end else begin
        rad = sq[63:0];
        root = 0;
        for (int k = 31; k >= 0; k--) begin
          trial = root | (64'd1 << k);
          if (128'(trial) * 128'(trial) <= 128'(rad)) root = trial;
        end
        rem = rad - root * root;
        if (rem > root) root = root + 1;
        res.distance = root > 64'h7FFF_FFFF ? DIST_MAX : root[30:0];
      end
      res.near_x = r[0][31:0];
      res.near_y = r[1][31:0];
      res.near_z = r[2][31:0];
      return res;
    endfunction

    function void note_input(in_item_t it);
      pending.push_back(project(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.near_x !== want.near_x)
        $display("%0t: near_x exp %h got %h", $time, want.near_x, got.near_x);
      if (got.near_y !== want.near_y)
        $display("%0t: near_y exp %h got %h", $time, want.near_y, got.near_y);
      if (got.near_z !== want.near_z)
        $display("%0t: near_z exp %h got %h", $time, want.near_z, got.near_z);
      if (got.distance !== want.distance)
        $display("%0t: distance exp %h got %h", $time, want.distance, got.distance);
      if (got.where_found !== want.where_found)
        $display("%0t: where_found exp %0d got %0d", $time, want.where_found,
                 got.where_found);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_item_t in_item;
  out_item_t out_item;
  projection_scoreboard board;
  int cycles;
  bit calm;

  point_segment_projection_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_input(in_item);
    if (rst_n && out_valid && out_ready) board.check_result(out_item);
  end

  // Receiver stalls in bursts until the calm tail of the run.
  initial begin
    int n;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      out_ready <= 1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end
    end
  end

  function logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 8) << 16;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function in_item_t make_item(logic [31:0] px, py, pz, ax, ay, az, bx, by, bz);
    in_item_t it;
    it = {px, py, pz, ax, ay, az, bx, by, bz};
    return it;
  endfunction

  initial begin
    in_item_t it;
    localparam logic [31:0] MN = 32'h8000_0000, MX = 32'h7FFF_FFFF, ONE = 32'h1_0000;
    board = new();
    cycles = 0;
    calm = 0;
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Degenerate segment, before A, past B, interior, feet on both endpoints.
    send_item(make_item(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
    send_item(make_item(-ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 0));
    send_item(make_item(3 * ONE, 5, 0, 0, 0, 0, 2 * ONE, 0, 0));
    send_item(make_item(ONE, 7 * ONE, 3, 0, 0, 0, 2 * ONE, 0, 0));
    send_item(make_item(0, ONE, 0, 0, 0, 0, 2 * ONE, 0, 0));
    send_item(make_item(2 * ONE, ONE, 0, 0, 0, 0, 2 * ONE, 0, 0));
    send_item(make_item(1, 0, 0, 0, 0, 0, 3, 1, 0));
    // Extremes of the range, saturated distance.
    send_item(make_item(MX, MX, MX, MN, MN, MN, MN, MN, MN));
    send_item(make_item(MN, MN, MN, MX, MX, MX, MX, MX, MX));
    send_item(make_item(MN, MX, MN, MN, MN, MN, MX, MX, MX));
    send_item(make_item(0, 0, 0, MN, MN, MN, MX, MX, MX));
    send_item(make_item(MX, MN, 0, MX, MX, MX, MN, MN, MN));
    send_item(make_item('1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_item(make_item(MX, 0, MN, 0, MN, MX, MN, MX, 0));
    for (int i = 0; i < 450; i++) begin
      if (i == 380) calm = 1;
      it = make_item(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     pick_coord());
      if ($urandom_range(0, 9) == 0) it.end_x = it.start_x;
      if ($urandom_range(0, 19) == 0) {it.end_y, it.end_z} = {it.start_y, it.start_z};
      send_item(it);
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/psp_pkg.sv
rtl/psp_front.sv
rtl/psp_div.sv
rtl/psp_sqrt.sv
rtl/psp_back.sv
rtl/point_segment_projection_core.sv
test/testbench.sv
